// ----- sv/stl_pkg.sv -----
// Shared types, constants and helper functions for the stopwatch lap display unit.
package stl_pkg;

	localparam int TICKS_PER_SECOND = 100;
	localparam int SEC_WRAP         = 6000;

	localparam int HUND_W = 7;
	localparam int SEC_W  = 13;
	localparam int SEG_W  = 7;

	// button bit positions
	localparam int BTN_START = 0;
	localparam int BTN_STOP  = 1;
	localparam int BTN_LAP   = 2;
	localparam int BTN_CLEAR = 3;

	localparam logic [HUND_W-1:0] HUND_LAST = HUND_W'(TICKS_PER_SECOND - 1);
	localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(SEC_WRAP - 1);

	// time selected for display, carried from front to back
	typedef struct packed {
		logic              run;
		logic [SEC_W-1:0]  sec;
		logic [HUND_W-1:0] hund;
	} stl_time_t;

	// queue status toward the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} stl_qstat_t;

	// tens digit of a value below 100: x*205 >> 11
	function automatic logic [3:0] div10(input logic [6:0] x);
		logic [14:0] p;
		p = {8'd0, x} * 15'd205;
		return p[14:11];
	endfunction

	// ones digit given the value and its tens digit
	function automatic logic [3:0] mod10(input logic [6:0] x, input logic [3:0] tens);
		logic [6:0] t10;
		logic [6:0] r;
		t10 = {3'd0, tens} * 7'd10;
		r   = x - t10;
		return r[3:0];
	endfunction

	// seven-segment code, bit0 = a .. bit6 = g
	function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0:    s = 7'h3F;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5B;
			4'd3:    s = 7'h4F;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6D;
			4'd6:    s = 7'h7D;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7F;
			4'd9:    s = 7'h6F;
			default: s = 7'h3F;
		endcase
		return s;
	endfunction

endpackage

// ----- sv/stl_front.sv -----
// Front end: holds the stopwatch state, applies each poll and picks the time to show.
module stl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              tick,
	input  logic [3:0]        buttons,
	input  logic              show_lap,
	output stl_pkg::stl_time_t wr_data
);
	import stl_pkg::*;

	logic              run_q;
	logic [HUND_W-1:0] hund_q;
	logic [SEC_W-1:0]  sec_q;
	logic [HUND_W-1:0] lap_hund_q;
	logic [SEC_W-1:0]  lap_sec_q;

	logic              run_n;
	logic [HUND_W-1:0] hund_t, hund_n;
	logic [SEC_W-1:0]  sec_t, sec_n;
	logic [HUND_W-1:0] lap_hund_n;
	logic [SEC_W-1:0]  lap_sec_n;

	// tick, then start/stop, then lap or clear
	always_comb begin
		hund_t = hund_q;
		sec_t  = sec_q;
		if (tick && run_q) begin
			if (hund_q == HUND_LAST) begin
				hund_t = '0;
				sec_t  = (sec_q == SEC_LAST) ? '0 : sec_q + 1'b1;
			end else begin
				hund_t = hund_q + 1'b1;
			end
		end

		run_n = run_q;
		if (buttons[BTN_START])
			run_n = 1'b1;
		else if (buttons[BTN_STOP])
			run_n = 1'b0;

		hund_n     = hund_t;
		sec_n      = sec_t;
		lap_hund_n = lap_hund_q;
		lap_sec_n  = lap_sec_q;
		if (buttons[BTN_LAP]) begin
			lap_hund_n = hund_t;
			lap_sec_n  = sec_t;
		end else if (buttons[BTN_CLEAR]) begin
			run_n      = 1'b0;
			hund_n     = '0;
			sec_n      = '0;
			lap_hund_n = '0;
			lap_sec_n  = '0;
		end
	end

	// displayed time for this poll
	always_comb begin
		wr_data.run  = run_n;
		wr_data.hund = show_lap ? lap_hund_n : hund_n;
		wr_data.sec  = show_lap ? lap_sec_n  : sec_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			hund_q     <= '0;
			sec_q      <= '0;
			lap_hund_q <= '0;
			lap_sec_q  <= '0;
		end else if (take) begin
			run_q      <= run_n;
			hund_q     <= hund_n;
			sec_q      <= sec_n;
			lap_hund_q <= lap_hund_n;
			lap_sec_q  <= lap_sec_n;
		end
	end

endmodule

// ----- sv/stl_queue.sv -----
// Two-entry queue between the front end and the display back end.
module stl_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  stl_pkg::stl_time_t wr_data,
	input  logic               rd_en,
	output stl_pkg::stl_time_t rd_data,
	output stl_pkg::stl_qstat_t stat
);
	import stl_pkg::*;

	stl_time_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign stat.full  = cnt_q[1];
	assign stat.empty = (cnt_q == 2'd0);
	assign rd_data    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en)
				wr_ptr_q <= ~wr_ptr_q;
			if (rd_en)
				rd_ptr_q <= ~rd_ptr_q;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 2'd1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ----- sv/stl_back.sv -----
// Back end: splits the time into digits and drives the seven-segment result register.
module stl_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  stl_pkg::stl_qstat_t     qstat,
	input  stl_pkg::stl_time_t      rd_data,
	output logic                    rd_en,
	input  logic                    pop,
	output logic                    empty,
	output logic [stl_pkg::SEG_W-1:0] seg_min_tens,
	output logic [stl_pkg::SEG_W-1:0] seg_min_ones,
	output logic [stl_pkg::SEG_W-1:0] seg_sec_tens,
	output logic [stl_pkg::SEG_W-1:0] seg_sec_ones,
	output logic [stl_pkg::SEG_W-1:0] seg_hund_tens,
	output logic [stl_pkg::SEG_W-1:0] seg_hund_ones,
	output logic                    running
);
	import stl_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	// stage 1: minutes = sec / 60 by reciprocal multiply
	logic [SEC_W-1:0]  sec_s1;
	logic [6:0]        min_s1;
	logic [HUND_W-1:0] hund_s1;
	logic              run_s1;
	logic [27:0]       min_prod;

	// stage 2: seconds remainder and tens digits
	logic [6:0] min_s2, secr_s2, hund_s2;
	logic [3:0] mt_s2, ht_s2;
	logic       run_s2;
	logic [SEC_W-1:0] min60;
	logic [SEC_W-1:0] secr_w;

	// handshake chain, back to front
	assign adv3  = !v_s3 || pop;
	assign adv2  = !v_s2 || adv3;
	assign adv1  = !v_s1 || adv2;
	assign rd_en = !qstat.empty && adv1;
	assign empty = !v_s3;

	assign min_prod = {15'd0, rd_data.sec} * 28'd17477;
	assign min60    = {6'd0, min_s1} * 13'd60;
	assign secr_w   = sec_s1 - min60;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= rd_en;
			if (adv2)
				v_s2 <= v_s1;
			if (adv3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && rd_en) begin
			sec_s1  <= rd_data.sec;
			min_s1  <= min_prod[26:20];
			hund_s1 <= rd_data.hund;
			run_s1  <= rd_data.run;
		end
		if (adv2 && v_s1) begin
			min_s2  <= min_s1;
			secr_s2 <= {1'b0, secr_w[5:0]};
			hund_s2 <= hund_s1;
			mt_s2   <= div10(min_s1);
			ht_s2   <= div10(hund_s1);
			run_s2  <= run_s1;
		end
		// stage 3: result register
		if (adv3 && v_s2) begin
			seg_min_tens  <= seg_of(mt_s2);
			seg_min_ones  <= seg_of(mod10(min_s2, mt_s2));
			seg_sec_tens  <= seg_of(div10(secr_s2));
			seg_sec_ones  <= seg_of(mod10(secr_s2, div10(secr_s2)));
			seg_hund_tens <= seg_of(ht_s2);
			seg_hund_ones <= seg_of(mod10(hund_s2, ht_s2));
			running       <= run_s2;
		end
	end

endmodule

// ----- sv/stopwatch_lap_seven_segment_unit.sv -----
// Top level of the stopwatch with lap memory and six-digit seven-segment output.
//
// Usage: each input beat is one poll (tick, buttons, show_lap), pushed while
// full is low. The front end updates run flag, hundredths, seconds and lap
// registers in the cycle the beat is accepted and queues the time to show.
// The back end splits it into MM:SS:hh digits and segment codes over three
// register stages; the result beat sits on the seg_* and running ports while
// empty is low and leaves on pop.
// Throughput: one poll per cycle while full is low; the state update is a single
// counter step, the digit split a three-stage pipeline.
// Reset (arst_n low): watch stopped, all times zero, queue and pipeline empty.
// When the receiver stalls, the pipeline fills, then the two-entry queue, and
// only then is full raised; state updates stay in step with accepted beats.
module stopwatch_lap_seven_segment_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       tick,
	input  logic [3:0] buttons,
	input  logic       show_lap,
	output logic       empty,
	input  logic       pop,
	output logic [6:0] seg_min_tens,
	output logic [6:0] seg_min_ones,
	output logic [6:0] seg_sec_tens,
	output logic [6:0] seg_sec_ones,
	output logic [6:0] seg_hund_tens,
	output logic [6:0] seg_hund_ones,
	output logic       running
);
	import stl_pkg::*;

	logic       take;
	logic       rd_en;
	stl_time_t  wr_data;
	stl_time_t  rd_data;
	stl_qstat_t qstat;

	assign full = qstat.full;
	assign take = push && !qstat.full;

	stl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.tick     (tick),
		.buttons  (buttons),
		.show_lap (show_lap),
		.wr_data  (wr_data)
	);

	stl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_data (rd_data),
		.stat    (qstat)
	);

	stl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qstat         (qstat),
		.rd_data       (rd_data),
		.rd_en         (rd_en),
		.pop           (pop),
		.empty         (empty),
		.seg_min_tens  (seg_min_tens),
		.seg_min_ones  (seg_min_ones),
		.seg_sec_tens  (seg_sec_tens),
		.seg_sec_ones  (seg_sec_ones),
		.seg_hund_tens (seg_hund_tens),
		.seg_hund_ones (seg_hund_ones),
		.running       (running)
	);

endmodule
